### rtl/ror_pkg.sv
// Shared types and constants for the in-order completion reorder block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ror_pkg;

    // Width of each saturating per-kind counter and its ceiling.
    localparam int CNT_BITS = 16;
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    // Number of counted kinds and the drain limit per item.
    localparam int KINDS       = 5;
    localparam int MAX_RESULTS = 16;
    localparam int NREL_BITS   = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        KIND_NORMAL  = 3'd0,
        KIND_DISC    = 3'd1,
        KIND_DENIED  = 3'd2,
        KIND_CUE     = 3'd3,
        KIND_UNKNOWN = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_WINDOW = 2'd1,
        ERR_DUP    = 2'd2,
        ERR_KIND   = 2'd3
    } err_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    // Controls broadcast from the sequencer to every window cell.
    typedef struct packed {
        logic shift;  // take the contents of the upstream neighbor
        logic write;  // this cell is the target of the current completion
        logic keep;   // the completion carries a payload
    } ror_cell_ctrl_t;

endpackage

### rtl/ror_cell.sv
// One slot of the reorder window: done mark, payload mark and payload.
// Depends on ror_pkg for the control struct.
`timescale 1ns / 1ps

module ror_cell #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ror_pkg::ror_cell_ctrl_t  ctrl,
    input  logic [PAYLOAD_BITS-1:0]  wr_payload,
    input  logic                     up_done,
    input  logic                     up_hold,
    input  logic [PAYLOAD_BITS-1:0]  up_payload,
    output logic                     done,
    output logic                     hold,
    output logic [PAYLOAD_BITS-1:0]  payload
);
    import ror_pkg::*;

    logic                    done_reg;
    logic                    hold_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            hold_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.write)
            begin
                done_reg <= 1'b1;
                hold_reg <= ctrl.keep;
            end
            else if (ctrl.shift)
            begin
                done_reg <= up_done;
                hold_reg <= up_hold;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.write && ctrl.keep)
        begin
            payload_reg <= wr_payload;
        end
        else if (ctrl.shift)
        begin
            payload_reg <= up_payload;
        end
    end

    assign done    = done_reg;
    assign hold    = hold_reg;
    assign payload = payload_reg;

endmodule

### rtl/ror_stats.sv
// Bank of saturating counters, one per legal result kind.
// Depends on ror_pkg for kind codes and counter width.
`timescale 1ns / 1ps

module ror_stats (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    inc,
    input  logic [2:0]                              kind,
    output logic [ror_pkg::KINDS-1:0][ror_pkg::CNT_BITS-1:0] counts
);
    import ror_pkg::*;

    logic [KINDS-1:0][CNT_BITS-1:0] count_reg;
    logic [KINDS-1:0][CNT_BITS-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        for (int k = 0; k < KINDS; k++)
        begin
            if (inc && (kind == 3'(k)) && (count_reg[k] != CNT_MAX))
            begin
                count_next[k] = count_reg[k] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign counts = count_reg;

endmodule

### rtl/in_order_completion_reorder.sv
// Top level of the in-order completion reorder block.
// Depends on ror_pkg, ror_cell (window slots) and ror_stats (kind counters).
//
// Usage: completions enter on the input channel (in_valid / in_stall) with a
// sequence tag, a kind and a payload handle. Each accepted item is checked
// (illegal kind, then tag outside the window, then duplicate), marked in its
// window slot and counted. The block then drains: every cycle the window, a
// row of WINDOW cells, shifts down by one slot while the lowest slot is done
// and neither a stalled output nor the drain limit holds it. Slots without
// payload pass silently; payload slots yield result items on the output
// channel (out_valid / out_stall) in tag order, at most MAX_RESULTS per input,
// the final one marked by last. When nothing is released, one result with
// file_valid low is given. All results of an item carry the error code and
// the counters after that item's update.
// Timing: one item is worked on at a time. It is accepted, drains its slots
// (one shift of the cell row each) and then issues the final result. The
// first result shows only once the drain has issued it into the output register.
// The output register lets the next item be accepted while the final result
// still waits. A stalled receiver holds the result steady and halts the
// drain only when a further result must be issued. Reset empties the window,
// zeroes the counters and sets the expected tag to zero.
`timescale 1ns / 1ps

module in_order_completion_reorder #(
    parameter int WINDOW       = 16,
    parameter int PAYLOAD_BITS = 32,
    parameter int TAG_BITS     = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [TAG_BITS-1:0]          task_tag,
    input  logic [2:0]                   file_kind,
    input  logic [PAYLOAD_BITS-1:0]      payload,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         file_valid,
    output logic [PAYLOAD_BITS-1:0]      released_payload,
    output logic                         last,
    output logic [ror_pkg::CNT_BITS-1:0] accepted_count,
    output logic [ror_pkg::CNT_BITS-1:0] rejected_count,
    output logic [ror_pkg::CNT_BITS-1:0] denied_count,
    output logic [ror_pkg::CNT_BITS-1:0] disc_track_count,
    output logic [ror_pkg::CNT_BITS-1:0] cue_sheet_count,
    output logic [1:0]                   error_code
);
    import ror_pkg::*;

    // Width wide enough to compare a tag distance against any window size.
    localparam int CMP_BITS = 33;

    state_t state_reg;
    state_t state_next;

    logic [TAG_BITS-1:0]     next_expected_reg;
    err_t                    err_reg;
    logic                    pend_valid_reg;
    logic [PAYLOAD_BITS-1:0] pend_payload_reg;
    logic [NREL_BITS-1:0]    nrel_reg;

    logic                           out_valid_reg;
    logic                           file_valid_reg;
    logic [PAYLOAD_BITS-1:0]        released_payload_reg;
    logic                           last_reg;
    logic [KINDS-1:0][CNT_BITS-1:0] counts_reg;
    err_t                           error_code_reg;

    logic [KINDS-1:0][CNT_BITS-1:0] counts;

    logic                    accept;
    logic [TAG_BITS-1:0]     tag_offset;
    logic                    in_window;
    logic [WINDOW-1:0]       hit;
    logic                    dup;
    err_t                    err_in;
    logic                    write_ok;
    logic                    out_free;

    logic                    shift_en;
    logic                    load_pend;
    logic                    emit;
    logic                    emit_last;

    logic                    done_w    [WINDOW];
    logic                    hold_w    [WINDOW];
    logic [PAYLOAD_BITS-1:0] payload_w [WINDOW];

    // ------------------------------------------------------------------
    // Input checks. The distance from the expected tag selects the slot;
    // every cell compares it against its own position.
    // ------------------------------------------------------------------
    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign tag_offset = task_tag - next_expected_reg;
    assign in_window  = (CMP_BITS'(tag_offset) < CMP_BITS'(WINDOW));

    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            hit[i] = (CMP_BITS'(tag_offset) == CMP_BITS'(i));
        end
    end

    always_comb
    begin
        dup = 1'b0;
        for (int i = 0; i < WINDOW; i++)
        begin
            dup = dup | (hit[i] & done_w[i]);
        end
    end

    always_comb
    begin
        priority if (file_kind > KIND_UNKNOWN)
        begin
            err_in = ERR_KIND;
        end
        else if (!in_window)
        begin
            err_in = ERR_WINDOW;
        end
        else if (dup)
        begin
            err_in = ERR_DUP;
        end
        else
        begin
            err_in = ERR_OK;
        end
    end

    assign write_ok = accept && (err_in == ERR_OK);

    // ------------------------------------------------------------------
    // Window: a row of cells, cell 0 holds the expected tag. A shift moves
    // every cell's contents one place toward cell 0; the top cell empties.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < WINDOW; g++)
    begin : g_cell
        ror_cell_ctrl_t          ctrl;
        logic                    up_done;
        logic                    up_hold;
        logic [PAYLOAD_BITS-1:0] up_payload;

        assign ctrl.shift = shift_en;
        assign ctrl.write = write_ok && hit[g];
        assign ctrl.keep  = (file_kind == KIND_NORMAL);

        if (g == WINDOW - 1)
        begin : g_top
            assign up_done    = 1'b0;
            assign up_hold    = 1'b0;
            assign up_payload = '0;
        end
        else
        begin : g_mid
            assign up_done    = done_w[g+1];
            assign up_hold    = hold_w[g+1];
            assign up_payload = payload_w[g+1];
        end

        ror_cell #(
            .PAYLOAD_BITS(PAYLOAD_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .wr_payload(payload),
            .up_done   (up_done),
            .up_hold   (up_hold),
            .up_payload(up_payload),
            .done      (done_w[g]),
            .hold      (hold_w[g]),
            .payload   (payload_w[g])
        );
    end

    ror_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (write_ok),
        .kind  (file_kind),
        .counts(counts)
    );

    // ------------------------------------------------------------------
    // Drain sequencer. A released payload is held back in the pending
    // register, so that the result issued from it knows whether
    // another one follows and can mark last correctly.
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        shift_en  = 1'b0;
        load_pend = 1'b0;
        emit      = 1'b0;
        emit_last = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_DRAIN:
            begin
                priority if (done_w[0] && !hold_w[0])
                begin
                    shift_en = 1'b1;
                end
                else if (done_w[0] && (nrel_reg < NREL_BITS'(MAX_RESULTS)))
                begin
                    if (!pend_valid_reg)
                    begin
                        load_pend = 1'b1;
                        shift_en  = 1'b1;
                    end
                    else if (out_free)
                    begin
                        emit      = 1'b1;
                        load_pend = 1'b1;
                        shift_en  = 1'b1;
                    end
                end
                else
                begin
                    // Gap reached or drain limit hit: issue the final result.
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            next_expected_reg <= '0;
            err_reg           <= ERR_OK;
            pend_valid_reg    <= 1'b0;
            nrel_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                err_reg        <= err_in;
                pend_valid_reg <= 1'b0;
                nrel_reg       <= '0;
            end
            else if (load_pend)
            begin
                pend_valid_reg <= 1'b1;
                nrel_reg       <= nrel_reg + 1'b1;
            end
            else if (emit_last)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (shift_en)
            begin
                next_expected_reg <= next_expected_reg + 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pend)
        begin
            pend_payload_reg <= payload_w[0];
        end
        if (emit)
        begin
            file_valid_reg       <= pend_valid_reg;
            released_payload_reg <= pend_valid_reg ? pend_payload_reg : '0;
            last_reg             <= emit_last;
            counts_reg           <= counts;
            error_code_reg       <= err_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign file_valid       = file_valid_reg;
    assign released_payload = released_payload_reg;
    assign last             = last_reg;
    assign accepted_count   = counts_reg[KIND_NORMAL];
    assign rejected_count   = counts_reg[KIND_UNKNOWN];
    assign denied_count     = counts_reg[KIND_DENIED];
    assign disc_track_count = counts_reg[KIND_DISC];
    assign cue_sheet_count  = counts_reg[KIND_CUE];
    assign error_code       = error_code_reg;

endmodule

### rtl/ror_checker.sv
// Port-level checks for the in-order completion reorder block, with the bind.
// Depends on ror_pkg and on the top level's port list.
`timescale 1ns / 1ps

module ror_checker #(
    parameter int PAYLOAD_BITS = 32
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic                    file_valid,
    input logic [PAYLOAD_BITS-1:0] released_payload,
    input logic                    last
);
    import ror_pkg::*;

    // An accepted item occupies the block for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after an item");

    // A result without a payload is always the only, and so last, result.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !file_valid) |-> (last && (released_payload == '0)))
        else $error("empty result not marked last or payload not zero");

    // Every result before the last one releases a payload.
    a_inner_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> file_valid)
        else $error("non-final result without payload");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(released_payload) && $stable(last)))
        else $error("stalled result changed");

endmodule

bind in_order_completion_reorder ror_checker #(
    .PAYLOAD_BITS(PAYLOAD_BITS)
) u_ror_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .file_valid      (file_valid),
    .released_payload(released_payload),
    .last            (last)
);
